/* hdl/snt_pkg.sv */
package snt_pkg;

	localparam logic [15:0]        EMPTY_ADDR = 16'hffff;
	localparam logic signed [7:0]  FLOOR_STR  = -8'sd127;
	localparam logic signed [7:0]  CEIL_STR   = 8'sd127;
	localparam logic [2:0]         NO_SLOT    = 3'b111;

	typedef struct packed {
		logic [15:0]       addr;
		logic signed [7:0] strength;
	} snt_req_t;

	typedef struct packed {
		logic     valid;
		snt_req_t req;
	} snt_qhead_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_MAXS,
		ST_EMIT
	} snt_state_t;

endpackage

/* hdl/snt_front.sv */
module snt_front import snt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              obs_valid,
	output logic              obs_stall,
	input  logic [15:0]       node_address,
	input  logic signed [7:0] signal_strength,
	output snt_qhead_t        head,
	input  logic              pop
);

	// two-entry request queue
	snt_req_t   mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign obs_stall = (cnt_q == 2'd2);
	assign push      = obs_valid && !obs_stall;

	assign head.valid = (cnt_q != 2'd0);
	assign head.req   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= '{addr: node_address, strength: signal_strength};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hdl/snt_back.sv */
module snt_back import snt_pkg::*; #(
	parameter int SLOTS = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  snt_qhead_t        head,
	output logic              pop,
	output logic              rep_valid,
	input  logic              rep_stall,
	output logic [1:0]        slot_index,
	output logic [15:0]       entry_address,
	output logic signed [7:0] entry_strength,
	output logic signed [2:0] strongest_slot,
	output logic              last_slot
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	snt_state_t state_q, state_d;

	logic [15:0]       addr_q [SLOTS];
	logic signed [7:0] str_q  [SLOTS];

	snt_req_t          req_q;
	logic [IW-1:0]     idx_q, idx_d;
	logic signed [7:0] low_q, high_q;
	logic [IW-1:0]     wslot_q, mslot_q, sslot_q;
	logic              wvalid_q, mfound_q, svalid_q;

	logic              rep_valid_q;
	logic [1:0]        rep_idx_q;
	logic [15:0]       rep_addr_q;
	logic signed [7:0] rep_str_q;
	logic signed [2:0] rep_strong_q;
	logic              rep_last_q;

	logic              idx_last;
	logic              load_out;
	logic              do_write;
	logic [15:0]       cur_addr;
	logic signed [7:0] cur_str;

	assign idx_last = (idx_q == LAST_IDX);
	assign cur_addr = addr_q[idx_q];
	assign cur_str  = str_q[idx_q];
	assign do_write = wvalid_q && (low_q <= req_q.strength);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (head.valid) state_d = ST_SCAN;
			ST_SCAN:   if (idx_last) state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_MAXS;
			ST_MAXS:   if (idx_last) state_d = ST_EMIT;
			ST_EMIT:   if (load_out && idx_last) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		idx_d    = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				pop   = head.valid;
				idx_d = '0;
			end
			ST_SCAN, ST_MAXS: begin
				idx_d = idx_last ? '0 : idx_q + 1'b1;
			end
			ST_UPDATE: begin
				idx_d = '0;
			end
			ST_EMIT: begin
				load_out = !rep_valid_q || !rep_stall;
				if (load_out) begin
					idx_d = idx_last ? '0 : idx_q + 1'b1;
				end
			end
			default: idx_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			rep_valid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				addr_q[i] <= EMPTY_ADDR;
				str_q[i]  <= FLOOR_STR;
			end
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load_out) begin
				rep_valid_q <= 1'b1;
			end else if (!rep_stall) begin
				rep_valid_q <= 1'b0;
			end
			if (state_q == ST_UPDATE && do_write) begin
				if (mfound_q) begin
					str_q[mslot_q] <= req_q.strength;
				end else begin
					addr_q[wslot_q] <= req_q.addr;
					str_q[wslot_q]  <= req_q.strength;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					req_q    <= head.req;
					low_q    <= CEIL_STR;
					wvalid_q <= 1'b0;
					mfound_q <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (cur_str < low_q) begin
					low_q    <= cur_str;
					wslot_q  <= idx_q;
					wvalid_q <= 1'b1;
				end
				if (!mfound_q && cur_addr == req_q.addr) begin
					mfound_q <= 1'b1;
					mslot_q  <= idx_q;
				end
			end
			ST_UPDATE: begin
				high_q   <= FLOOR_STR;
				svalid_q <= 1'b0;
			end
			ST_MAXS: begin
				if (cur_str >= high_q) begin
					high_q   <= cur_str;
					sslot_q  <= idx_q;
					svalid_q <= 1'b1;
				end
			end
			default: ;
		endcase
		if (load_out) begin
			rep_idx_q    <= 2'(idx_q);
			rep_addr_q   <= cur_addr;
			rep_str_q    <= cur_str;
			rep_strong_q <= svalid_q ? 3'(sslot_q) : NO_SLOT;
			rep_last_q   <= idx_last;
		end
	end

	assign rep_valid      = rep_valid_q;
	assign slot_index     = rep_idx_q;
	assign entry_address  = rep_addr_q;
	assign entry_strength = rep_str_q;
	assign strongest_slot = rep_strong_q;
	assign last_slot      = rep_last_q;

endmodule

/* hdl/strongest_neighbour_table.sv */
// channel   | handshake            | payload
// ----------+----------------------+----------------------------------------------
// obs       | obs_valid, obs_stall | node_address, signal_strength
// rep       | rep_valid, rep_stall | slot_index, entry_address, entry_strength,
//           |                      | strongest_slot, last_slot
//
// In the back end each request passes through a pop step, a weakest/match
// scan of one slot per cycle, an update step, a strongest-slot scan of one
// slot per cycle, then one report per slot.
// A two-entry queue in front takes requests while the back end is busy.
// Reset sets every slot to address 0xffff, strength -127.
// rep_stall holds the report register and pauses the emit phase.
module strongest_neighbour_table import snt_pkg::*; #(
	parameter int SLOTS = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              obs_valid,
	output logic              obs_stall,
	input  logic [15:0]       node_address,
	input  logic signed [7:0] signal_strength,
	output logic              rep_valid,
	input  logic              rep_stall,
	output logic [1:0]        slot_index,
	output logic [15:0]       entry_address,
	output logic signed [7:0] entry_strength,
	output logic signed [2:0] strongest_slot,
	output logic              last_slot
);

	snt_qhead_t head;
	logic       pop;

	snt_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.obs_valid       (obs_valid),
		.obs_stall       (obs_stall),
		.node_address    (node_address),
		.signal_strength (signal_strength),
		.head            (head),
		.pop             (pop)
	);

	snt_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.rep_valid      (rep_valid),
		.rep_stall      (rep_stall),
		.slot_index     (slot_index),
		.entry_address  (entry_address),
		.entry_strength (entry_strength),
		.strongest_slot (strongest_slot),
		.last_slot      (last_slot)
	);

`ifndef ASSERT_OFF
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && last_slot |-> slot_index == 2'(SLOTS - 1))
		else $error("last_slot on wrong slot index");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && !rep_stall && !last_slot |=>
		!rep_valid || slot_index == $past(slot_index) + 2'd1)
		else $error("slot index did not advance within snapshot");

	a_strong_same: assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && !rep_stall && !last_slot |=>
		!rep_valid || strongest_slot == $past(strongest_slot))
		else $error("strongest slot changed within snapshot");
`endif

endmodule

/* tb/strongest_neighbour_table_tb.sv */
typedef struct packed {
	logic [1:0]        slot;
	logic [15:0]       addr;
	logic signed [7:0] strength;
	logic signed [2:0] strongest;
	logic              last;
} slot_report_t;

class neighbour_scoreboard;
	logic [15:0]       table_addr[3];
	logic signed [7:0] table_str[3];
	slot_report_t      pending_reports[$];
	int                errors;

	function new();
		for (int n = 0; n < 3; n++) begin
			table_addr[n] = snt_pkg::EMPTY_ADDR;
			table_str[n]  = snt_pkg::FLOOR_STR;
		end
		errors = 0;
	endfunction

	function int weakest_slot();
		int best;
		int low;
		best = -1;
		low  = 127;
		for (int n = 0; n < 3; n++) begin
			if (int'(table_str[n]) < low) begin
				low  = int'(table_str[n]);
				best = n;
			end
		end
		return best;
	endfunction

	function int lowest_strength();
		int low;
		low = 127;
		for (int n = 0; n < 3; n++)
			if (int'(table_str[n]) < low)
				low = int'(table_str[n]);
		return low;
	endfunction

	function int slot_of(logic [15:0] a);
		for (int n = 0; n < 3; n++)
			if (table_addr[n] == a)
				return n;
		return -1;
	endfunction

	function bit table_saturated();
		return weakest_slot() < 0;
	endfunction

	function int pending();
		return pending_reports.size();
	endfunction

	// update the table for one request and queue the three slot reports
	function void note_request(logic [15:0] a, logic signed [7:0] s);
		int w;
		int m;
		int best;
		int high;
		slot_report_t rep;
		w = weakest_slot();
		if (w >= 0 && int'(table_str[w]) <= int'(s)) begin
			m = slot_of(a);
			if (m >= 0) begin
				table_str[m] = s;
			end else begin
				table_addr[w] = a;
				table_str[w]  = s;
			end
		end
		best = -1;
		high = -127;
		for (int n = 0; n < 3; n++) begin
			if (int'(table_str[n]) >= high) begin
				high = int'(table_str[n]);
				best = n;
			end
		end
		for (int n = 0; n < 3; n++) begin
			rep.slot      = n[1:0];
			rep.addr      = table_addr[n];
			rep.strength  = table_str[n];
			rep.strongest = best[2:0];
			rep.last      = (n == 2);
			pending_reports.push_back(rep);
		end
	endfunction

	task report_error(string msg);
		if (errors < 50)
			$display("ERROR at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task check_result(slot_report_t got);
		slot_report_t want;
		if (pending_reports.size() == 0) begin
			report_error($sformatf("unexpected report for slot %0d", got.slot));
			return;
		end
		want = pending_reports.pop_front();
		if (got.slot !== want.slot)
			report_error($sformatf("slot_index %0d, expected %0d", got.slot, want.slot));
		if (got.addr !== want.addr)
			report_error($sformatf("slot %0d entry_address %h, expected %h",
				want.slot, got.addr, want.addr));
		if (got.strength !== want.strength)
			report_error($sformatf("slot %0d entry_strength %0d, expected %0d",
				want.slot, got.strength, want.strength));
		if (got.strongest !== want.strongest)
			report_error($sformatf("slot %0d strongest_slot %0d, expected %0d",
				want.slot, got.strongest, want.strongest));
		if (got.last !== want.last)
			report_error($sformatf("slot %0d last_slot %b, expected %b",
				want.slot, got.last, want.last));
	endtask
endclass

module strongest_neighbour_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              obs_valid = 1'b0;
	logic              obs_stall;
	logic [15:0]       node_address = '0;
	logic signed [7:0] signal_strength = '0;
	logic              rep_valid;
	logic              rep_stall = 1'b0;
	logic [1:0]        slot_index;
	logic [15:0]       entry_address;
	logic signed [7:0] entry_strength;
	logic signed [2:0] strongest_slot;
	logic              last_slot;

	bit                  idling = 1'b1;
	neighbour_scoreboard board = new();

	strongest_neighbour_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.obs_valid(obs_valid),
		.obs_stall(obs_stall),
		.node_address(node_address),
		.signal_strength(signal_strength),
		.rep_valid(rep_valid),
		.rep_stall(rep_stall),
		.slot_index(slot_index),
		.entry_address(entry_address),
		.entry_strength(entry_strength),
		.strongest_slot(strongest_slot),
		.last_slot(last_slot)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && rep_valid === 1'b1 && !rep_stall)
			board.check_result({slot_index, entry_address, entry_strength,
				strongest_slot, last_slot});
		rep_stall <= idling && ($urandom_range(0, 99) < 33);
	end

	task automatic send_request(input logic [15:0] a, input int s);
		while (idling && $urandom_range(0, 99) < 33) begin
			obs_valid <= 1'b0;
			@(posedge clk);
		end
		obs_valid       <= 1'b1;
		node_address    <= a;
		signal_strength <= s[7:0];
		do @(posedge clk); while (obs_stall);
		board.note_request(a, s[7:0]);
	endtask

	task automatic drain_reports();
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int               r;
		int               s;
		int               lo;
		logic [15:0]      a;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(16'hffff, -128);
		send_request(16'hffff, -127);
		send_request(16'h0000, 127);
		send_request(16'h1234, -127);
		send_request(16'habcd, -127);
		send_request(16'h1234, 40);
		send_request(16'habcd, -128);
		send_request(16'h7fff, -100);
		send_request(16'h0000, -100);
		send_request(16'h8000, -100);
		send_request(16'hffff, -99);
		send_request(16'h5a5a, 0);
		send_request(16'hffff, 126);
		send_request(16'h8000, -128);

		obs_valid <= 1'b0;
		@(posedge clk);
		drain_reports();

		for (int i = 0; i < 290; i++) begin
			idling = !(i >= 100 && i < 180);
			r  = $urandom_range(0, 99);
			lo = board.lowest_strength();
			s  = lo - 2 + int'($urandom_range(0, 4));
			if (r < 50) begin
				a = 16'($urandom_range(0, 65535));
			end else if (r < 75) begin
				a = board.table_addr[$urandom_range(0, 2)];
			end else if (r < 85) begin
				a = 16'hffff;
			end else begin
				a = 16'($urandom_range(0, 65535));
				s = int'($urandom_range(0, 255)) - 128;
			end
			if (s < -128)
				s = -128;
			if (s > 126)
				s = 126;
			send_request(a, s);
		end
		idling = 1'b1;

		// fill every slot with the ceiling so the table locks
		while (!board.table_saturated()) begin
			do a = 16'($urandom_range(0, 65535)); while (board.slot_of(a) >= 0);
			send_request(a, 127);
		end
		send_request(16'h0001, 127);
		send_request(16'hffff, -128);
		send_request(board.table_addr[1], 127);
		obs_valid <= 1'b0;

		drain_reports();
		repeat (30) @(posedge clk);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
